// File: hdl/cts_pkg.sv
// Shared constants and tables for the cosine Taylor series core.
package cts_pkg;

    // Series limits and output format
    localparam int MAX_TERMS        = 32;
    localparam int RESULT_FRAC_BITS = 30;

    // Field widths
    localparam int ANGLE_W   = 32;
    localparam int COS_W     = 32;
    localparam int RED_W     = 19;
    localparam int TERMS_W   = 6;
    localparam int PREC_W    = 4;

    // Internal datapath widths
    localparam int MAG_W     = 48;   // term magnitude, 32 fraction bits
    localparam int SUM_W     = 48;   // signed running sum, 32 fraction bits
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = $clog2(MAX_TERMS);

    // Truncated 2*pi in Q16.16 and the range reduction schedule
    localparam logic [RED_W-1:0] TWO_PI_Q16 = 19'd411774;
    localparam int RED_STEPS = 14;   // 411774 << 13 is the largest power-of-two multiple below 2^32
    localparam int RED_CNT_W = $clog2(RED_STEPS);

    // Precision register
    localparam logic [PREC_W-1:0] PREC_RESET = 4'd6;
    localparam logic [PREC_W-1:0] PREC_MAX   = 4'd9;

    // Stopping thresholds round(2^32 * 10^-k)
    localparam logic [32:0] THRESH [0:9] = '{
        33'd4294967296, 33'd429496730, 33'd42949673, 33'd4294967, 33'd429497,
        33'd42950,      33'd4295,      33'd429,      33'd43,       33'd4
    };

    // Reciprocals round(2^32 / ((2n+1)(2n+2))) in Q0.32
    localparam logic [31:0] RECIP [0:MAX_TERMS-1] = '{
        32'd2147483648, 32'd357913941, 32'd143165577, 32'd76695845,
        32'd47721859,   32'd32537631,  32'd23598721,  32'd17895697,
        32'd14035841,   32'd11302546,  32'd9296466,   32'd7780738,
        32'd6607642,    32'd5681174,   32'd4936744,   32'd4329604,
        32'd3827957,    32'd3408704,   32'd3054742,   32'd2753184,
        32'd2494174,    32'd2270067,   32'd2074863,   32'd1903798,
        32'd1753048,    32'd1619520,   32'd1500687,   32'd1394470,
        32'd1299143,    32'd1213268,   32'd1135634,   32'd1065220
    };

endpackage

// File: hdl/cosine_taylor_series_core.sv
// Cosine by Taylor series with range reduction, one shared 32x32 multiplier.
//
// Usage: pulse start while busy is low to hand over one angle (signed Q16.16).
// The angle is reduced modulo the truncated 2*pi by compare/subtract steps on
// shifted multiples of it and a wrap step. Each series term then takes three
// multiplications (by x, by x, by the reciprocal table entry), each done as two
// 32x32 partial products on the single shared multiplier plus a step to combine
// them, and a step to update the sum. busy stays high from the accepting edge
// through the final step. The result shows in the next cycle, and the next item
// can be accepted at the edge that ends that cycle. At most 16 terms are needed
// for any reduced angle, even at nine digits. With the zero precision setting,
// busy is high for one cycle and the result follows in the next.
// The result shows on the o_ ports for exactly one cycle with o_valid high;
// the receiver cannot stall it, so it must take it in that cycle.
// Write the precision register only while busy is low.
module cosine_taylor_series_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [cts_pkg::ANGLE_W-1:0]     i_angle,
    input  logic                                   i_cfg_we,
    input  logic        [cts_pkg::PREC_W-1:0]      i_cfg_wdata,
    output logic                                   o_valid,
    output logic signed [cts_pkg::COS_W-1:0]       o_cosine,
    output logic        [cts_pkg::RED_W-1:0]       o_reduced_angle,
    output logic        [cts_pkg::TERMS_W-1:0]     o_terms_used,
    output logic                                   o_precision_error
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_FIXUP  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;

    // Multiply operations within one term
    localparam logic [1:0] OP_X1    = 2'd0;
    localparam logic [1:0] OP_X2    = 2'd1;
    localparam logic [1:0] OP_RECIP = 2'd2;

    // Partial product phases
    localparam logic [1:0] PH_LO    = 2'd0;
    localparam logic [1:0] PH_HI    = 2'd1;
    localparam logic [1:0] PH_SUM   = 2'd2;

    localparam int COS_W_L = cts_pkg::COS_W;

    // Output format conversion
    localparam int  SH_DN = (cts_pkg::RESULT_FRAC_BITS <= 32) ?
                            32 - cts_pkg::RESULT_FRAC_BITS : 0;
    localparam int  SH_UP = (cts_pkg::RESULT_FRAC_BITS > 60) ? 28 :
                            (cts_pkg::RESULT_FRAC_BITS > 32) ?
                            cts_pkg::RESULT_FRAC_BITS - 32 : 0;
    localparam logic signed [63:0] ROUND = (SH_DN == 0) ? 64'sd0 :
                                           64'sd1 <<< (SH_DN - 1);
    localparam logic signed [63:0] CLAMP = 64'sd1 <<< 33;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    logic [2:0]                         r_state, n_state;
    logic [cts_pkg::PREC_W-1:0]         r_precision;
    logic [31:0]                        r_thresh, n_thresh;
    logic                               r_err, n_err;
    logic [31:0]                        r_rem, n_rem;
    logic                               r_ang_neg, n_ang_neg;
    logic [cts_pkg::RED_CNT_W-1:0]      r_cnt, n_cnt;
    logic [cts_pkg::RED_W-1:0]          r_x, n_x;
    logic [cts_pkg::MAG_W-1:0]          r_mag, n_mag;
    logic signed [cts_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic                               r_neg, n_neg;
    logic [cts_pkg::CNT_W-1:0]          r_terms, n_terms;
    logic [1:0]                         r_op, n_op;
    logic [1:0]                         r_phase, n_phase;
    logic [63:0]                        r_prod, n_prod;
    logic [63:0]                        r_lo, n_lo;

    logic [cts_pkg::PREC_W-1:0]         prec_k;
    logic [31:0]                        red_sub;
    logic [31:0]                        mul_a, mul_b;
    logic [63:0]                        mul_p;
    logic [79:0]                        comb_p;
    logic signed [63:0]                 res_wide, res_clamp;
    logic signed [COS_W_L-1:0]          res_sat;

    // Precision register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision <= cts_pkg::PREC_RESET;
        end else if (i_cfg_we) begin
            r_precision <= i_cfg_wdata;
        end
    end

    assign prec_k = (r_precision > cts_pkg::PREC_MAX) ? cts_pkg::PREC_MAX : r_precision;
    assign busy   = (r_state != S_IDLE);

    // Shared compare/subtract step of the range reduction
    assign red_sub = 32'(cts_pkg::TWO_PI_Q16) << r_cnt;

    // Shared multiplier: low or high half of the magnitude by x or a reciprocal
    assign mul_a  = (r_phase == PH_LO) ? r_mag[31:0] : 32'(r_mag[cts_pkg::MAG_W-1:32]);
    assign mul_b  = (r_op == OP_RECIP) ? cts_pkg::RECIP[r_terms[cts_pkg::IDX_W-1:0]]
                                       : 32'(r_x);
    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign comb_p = 80'(r_lo) + {r_prod[cts_pkg::MAG_W-1:0], 32'd0};

    // Sum to output format: round half up going down, shift going up, saturate
    always_comb begin
        res_clamp = 64'(r_sum);
        if (cts_pkg::RESULT_FRAC_BITS <= 32) begin
            res_wide = (64'(r_sum) + ROUND) >>> SH_DN;
        end else begin
            if (res_clamp > CLAMP) begin
                res_clamp = CLAMP;
            end
            if (res_clamp < -CLAMP) begin
                res_clamp = -CLAMP;
            end
            res_wide = res_clamp <<< SH_UP;
        end
        if (res_wide > SAT_HI) begin
            res_sat = COS_W_L'(SAT_HI);
        end else if (res_wide < SAT_LO) begin
            res_sat = COS_W_L'(SAT_LO);
        end else begin
            res_sat = COS_W_L'(res_wide);
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_thresh  = r_thresh;
        n_err     = r_err;
        n_rem     = r_rem;
        n_ang_neg = r_ang_neg;
        n_cnt     = r_cnt;
        n_x       = r_x;
        n_mag     = r_mag;
        n_sum     = r_sum;
        n_neg     = r_neg;
        n_terms   = r_terms;
        n_op      = r_op;
        n_phase   = r_phase;
        n_prod    = r_prod;
        n_lo      = r_lo;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_thresh  = 32'(cts_pkg::THRESH[prec_k]);
                    n_ang_neg = i_angle[cts_pkg::ANGLE_W-1];
                    n_rem     = i_angle[cts_pkg::ANGLE_W-1] ? 32'(-i_angle) : 32'(i_angle);
                    n_cnt     = cts_pkg::RED_CNT_W'(cts_pkg::RED_STEPS - 1);
                    if (r_precision == '0) begin
                        n_err   = 1'b1;
                        n_state = S_FINAL;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (r_rem >= red_sub) begin
                    n_rem = r_rem - red_sub;
                end
                if (r_cnt == '0) begin
                    n_state = S_FIXUP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIXUP: begin
                // Truncating remainder of a negative angle wraps to the positive side
                if (r_ang_neg && (r_rem != '0)) begin
                    n_x = cts_pkg::TWO_PI_Q16 - r_rem[cts_pkg::RED_W-1:0];
                end else begin
                    n_x = r_rem[cts_pkg::RED_W-1:0];
                end
                n_mag   = cts_pkg::MAG_W'(64'd1 << 32);
                n_sum   = cts_pkg::SUM_W'(64'd1 << 32);
                n_neg   = 1'b0;
                n_terms = '0;
                n_op    = OP_X1;
                n_phase = PH_LO;
                n_state = S_MUL;
            end
            S_MUL: begin
                case (r_phase)
                    PH_LO: begin
                        n_prod  = mul_p;
                        n_phase = PH_HI;
                    end
                    PH_HI: begin
                        n_lo    = r_prod;
                        n_prod  = mul_p;
                        n_phase = PH_SUM;
                    end
                    default: begin
                        n_phase = PH_LO;
                        if (r_op == OP_RECIP) begin
                            n_mag   = comb_p[cts_pkg::MAG_W+31:32];
                            n_op    = OP_X1;
                            n_state = S_ADD;
                        end else begin
                            n_mag = comb_p[cts_pkg::MAG_W+15:16];
                            n_op  = (r_op == OP_X1) ? OP_X2 : OP_RECIP;
                        end
                    end
                endcase
            end
            S_ADD: begin
                n_neg   = !r_neg;
                n_terms = r_terms + 1'b1;
                if (!r_neg) begin
                    n_sum = r_sum - $signed(cts_pkg::SUM_W'(r_mag));
                end else begin
                    n_sum = r_sum + $signed(cts_pkg::SUM_W'(r_mag));
                end
                if ((r_mag > cts_pkg::MAG_W'(r_thresh)) &&
                    (n_terms < cts_pkg::CNT_W'(cts_pkg::MAX_TERMS))) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_FINAL);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_thresh  <= n_thresh;
        r_err     <= n_err;
        r_rem     <= n_rem;
        r_ang_neg <= n_ang_neg;
        r_cnt     <= n_cnt;
        r_x       <= n_x;
        r_mag     <= n_mag;
        r_sum     <= n_sum;
        r_neg     <= n_neg;
        r_terms   <= n_terms;
        r_op      <= n_op;
        r_phase   <= n_phase;
        r_prod    <= n_prod;
        r_lo      <= n_lo;
    end

    // Result registers, shown for one cycle with o_valid
    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL) begin
            if (r_err) begin
                o_cosine          <= '0;
                o_reduced_angle   <= '0;
                o_terms_used      <= '0;
                o_precision_error <= 1'b1;
            end else begin
                o_cosine          <= res_sat;
                o_reduced_angle   <= r_x;
                o_terms_used      <= cts_pkg::TERMS_W'(r_terms);
                o_precision_error <= 1'b0;
            end
        end
    end

endmodule
